// ===== design/nct_pkg.sv =====
// Shared types and constants for the neighbour cache table.
package nct_pkg;

  localparam int NCT_ENTRIES        = 4;
  localparam int NCT_LINK_ADDR_BITS = 48;
  localparam int TARGET_W           = 64;
  localparam int PORT_LINK_W        = 48;
  localparam int OPT_LEN_W          = 8;
  localparam int RES_W              = 3;

  // Stored state of one cache entry.
  typedef enum logic [1:0] {
    ST_INVALID    = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_REACHABLE  = 2'd2
  } entry_state_t;

  // Result codes returned with every item.
  typedef enum logic [RES_W-1:0] {
    RES_HIT         = 3'd0,
    RES_AWAIT       = 3'd1,
    RES_MISS        = 3'd2,
    RES_UPDATED     = 3'd3,
    RES_UNSOLICITED = 3'd4,
    RES_UNKNOWN     = 3'd5,
    RES_BAD_OPTION  = 3'd6
  } res_code_t;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_ADVERT  = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [TARGET_W-1:0]   target_high;
    logic [TARGET_W-1:0]   target_low;
    logic                  solicited;
    logic                  has_target_option;
    logic [OPT_LEN_W-1:0]  option_length;
    logic [PORT_LINK_W-1:0] link_address_in;
  } req_t;

  typedef struct packed {
    res_code_t              status;
    logic [PORT_LINK_W-1:0] link_address_out;
    logic                   send_solicit;
  } rsp_t;

  // Control part of the lookup token that walks the cell chain.
  typedef struct packed {
    logic active;
    logic found;
    logic reachable;
  } probe_t;

  // Write command broadcast to all cells.
  typedef struct packed {
    logic         en;
    logic         set_key;
    entry_state_t new_status;
  } wr_cmd_t;

endpackage

// ===== design/nct_cell.sv =====
// One cache entry with its stage of the lookup chain.
module nct_cell #(
  parameter int ENTRIES        = nct_pkg::NCT_ENTRIES,
  parameter int LINK_ADDR_BITS = nct_pkg::NCT_LINK_ADDR_BITS,
  parameter int IDX            = 0,
  localparam int IDX_W         = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [nct_pkg::TARGET_W-1:0] query_high,
  input  logic [nct_pkg::TARGET_W-1:0] query_low,
  input  nct_pkg::probe_t              probe_in,
  input  logic [IDX_W-1:0]             probe_idx_in,
  input  logic [LINK_ADDR_BITS-1:0]    probe_link_in,
  output nct_pkg::probe_t              probe_out,
  output logic [IDX_W-1:0]             probe_idx_out,
  output logic [LINK_ADDR_BITS-1:0]    probe_link_out,
  input  nct_pkg::wr_cmd_t             wr,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [LINK_ADDR_BITS-1:0]    wr_link
);

  logic [nct_pkg::TARGET_W-1:0] key_high;
  logic [nct_pkg::TARGET_W-1:0] key_low;
  logic [LINK_ADDR_BITS-1:0]    link;
  nct_pkg::entry_state_t        status;
  logic                         match;
  logic                         take;
  logic                         wr_here;

  assign match = (status != nct_pkg::ST_INVALID) &&
                 (key_high == query_high) && (key_low == query_low);
  // The lowest matching index claims the token; later cells pass it on.
  assign take    = probe_in.active && !probe_in.found && match;
  assign wr_here = wr.en && (wr_idx == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= nct_pkg::ST_INVALID;
      probe_out <= '0;
    end else begin
      if (wr_here) begin
        status <= wr.new_status;
      end
      probe_out.active <= probe_in.active;
      if (take) begin
        probe_out.found     <= 1'b1;
        probe_out.reachable <= (status == nct_pkg::ST_REACHABLE);
      end else begin
        probe_out.found     <= probe_in.found;
        probe_out.reachable <= probe_in.reachable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      link <= wr_link;
      if (wr.set_key) begin
        key_high <= query_high;
        key_low  <= query_low;
      end
    end
    if (take) begin
      probe_idx_out  <= IDX_W'(IDX);
      probe_link_out <= link;
    end else begin
      probe_idx_out  <= probe_idx_in;
      probe_link_out <= probe_link_in;
    end
  end

endmodule

// ===== design/nct_ctrl.sv =====
// Handshake, request decode and replacement control for the neighbour cache.
module nct_ctrl #(
  parameter int ENTRIES        = nct_pkg::NCT_ENTRIES,
  parameter int LINK_ADDR_BITS = nct_pkg::NCT_LINK_ADDR_BITS,
  localparam int IDX_W         = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nct_pkg::req_t                req,
  input  logic                         req_valid,
  output logic                         req_ready,
  output nct_pkg::rsp_t                rsp,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [nct_pkg::TARGET_W-1:0] query_high,
  output logic [nct_pkg::TARGET_W-1:0] query_low,
  output nct_pkg::probe_t              launch,
  input  nct_pkg::probe_t              chain_probe,
  input  logic [IDX_W-1:0]             chain_idx,
  input  logic [LINK_ADDR_BITS-1:0]    chain_link,
  output nct_pkg::wr_cmd_t             wr,
  output logic [IDX_W-1:0]             wr_idx,
  output logic [LINK_ADDR_BITS-1:0]    wr_link
);

  // Option length in 8-byte units that carries a link address of this size.
  localparam int OPTION_UNITS = (2 + LINK_ADDR_BITS / 8) / 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                    state;
  logic                      op;
  logic                      solicited;
  logic                      opt_ok;
  logic [LINK_ADDR_BITS-1:0] link_in;
  logic [IDX_W-1:0]          next_slot;
  logic                      found;
  logic                      reachable;
  logic [IDX_W-1:0]          found_idx;
  logic [LINK_ADDR_BITS-1:0] found_link;
  logic                      accept;
  logic                      finish;
  nct_pkg::rsp_t             rsp_next;
  logic [IDX_W-1:0]          next_slot_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  assign next_slot_next = (next_slot == IDX_W'(ENTRIES - 1)) ? '0 : next_slot + 1'b1;

  always_comb begin
    rsp_next = '0;
    wr       = '0;
    wr_idx   = found_idx;
    wr_link  = '0;
    if (op == nct_pkg::OP_RESOLVE) begin
      priority if (found && reachable) begin
        rsp_next.status           = nct_pkg::RES_HIT;
        rsp_next.link_address_out = nct_pkg::PORT_LINK_W'(found_link);
      end else if (found) begin
        rsp_next.status = nct_pkg::RES_AWAIT;
      end else begin
        rsp_next.status       = nct_pkg::RES_MISS;
        rsp_next.send_solicit = 1'b1;
        wr.en         = finish;
        wr.set_key    = 1'b1;
        wr.new_status = nct_pkg::ST_INCOMPLETE;
        wr_idx        = next_slot;
      end
    end else begin
      priority if (!solicited) begin
        rsp_next.status = nct_pkg::RES_UNSOLICITED;
      end else if (!found) begin
        rsp_next.status = nct_pkg::RES_UNKNOWN;
      end else if (opt_ok) begin
        rsp_next.status = nct_pkg::RES_UPDATED;
        wr.en         = finish;
        wr.new_status = nct_pkg::ST_REACHABLE;
        wr_link       = link_in;
      end else begin
        rsp_next.status = nct_pkg::RES_BAD_OPTION;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= '0;
      rsp_valid <= 1'b0;
      next_slot <= '0;
    end else begin
      launch.active    <= accept;
      launch.found     <= 1'b0;
      launch.reachable <= 1'b0;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain_probe.active) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            state <= S_IDLE;
            if (op == nct_pkg::OP_RESOLVE && !found) begin
              next_slot <= next_slot_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req.opcode;
      query_high <= req.target_high;
      query_low  <= req.target_low;
      solicited  <= req.solicited;
      opt_ok     <= req.has_target_option &&
                    (req.option_length == nct_pkg::OPT_LEN_W'(OPTION_UNITS));
      link_in    <= req.link_address_in[LINK_ADDR_BITS-1:0];
    end
    if (state == S_SCAN && chain_probe.active) begin
      found      <= chain_probe.found;
      reachable  <= chain_probe.reachable;
      found_idx  <= chain_idx;
      found_link <= chain_link;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== design/neighbour_cache_table.sv =====
// Top level of the neighbour cache table: controller and chain of entry cells.
//
// Usage: a request item arrives on req/req_valid/req_ready and one response
// item leaves on rsp/rsp_valid/rsp_ready for every accepted request. A
// resolve request either returns a reachable entry's link address, reports
// that a reply is awaited, or inserts an incomplete entry into the
// round-robin slot and raises send_solicit. A solicited advertisement with a
// well-formed target link option fills in a cached entry.
// The lookup runs as a token that moves one cell per clock down a chain of
// ENTRIES cells, each holding one entry and comparing its 128-bit key. The
// first matching cell claims the token. The controller then writes at most
// one entry and loads the response register.
// Sequencing: after acceptance the token passes the launch register and
// each cell register, then the controller steps through scan and finish; a
// new request is taken only once the controller is back in idle.
// Reset clears every entry to invalid and the round-robin pointer to zero,
// and the block is ready right away. When the receiver stalls, the response
// register holds its item; the next request is still accepted and walks the
// chain, then waits until the held response has been taken.
module neighbour_cache_table #(
  parameter int ENTRIES        = nct_pkg::NCT_ENTRIES,
  parameter int LINK_ADDR_BITS = nct_pkg::NCT_LINK_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  nct_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_ready,
  output nct_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_ready
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [nct_pkg::TARGET_W-1:0] query_high;
  logic [nct_pkg::TARGET_W-1:0] query_low;
  nct_pkg::wr_cmd_t             wr;
  logic [IDX_W-1:0]             wr_idx;
  logic [LINK_ADDR_BITS-1:0]    wr_link;

  // Token links between neighboring cells; element 0 feeds the first cell.
  nct_pkg::probe_t           probe [ENTRIES+1];
  logic [IDX_W-1:0]          probe_idx [ENTRIES+1];
  logic [LINK_ADDR_BITS-1:0] probe_link [ENTRIES+1];

  assign probe_idx[0]  = '0;
  assign probe_link[0] = '0;

  nct_ctrl #(
    .ENTRIES        (ENTRIES),
    .LINK_ADDR_BITS (LINK_ADDR_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .rsp         (rsp),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .query_high  (query_high),
    .query_low   (query_low),
    .launch      (probe[0]),
    .chain_probe (probe[ENTRIES]),
    .chain_idx   (probe_idx[ENTRIES]),
    .chain_link  (probe_link[ENTRIES]),
    .wr          (wr),
    .wr_idx      (wr_idx),
    .wr_link     (wr_link)
  );

  // One cell per entry; the lowest index sits first so it wins a lookup.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    nct_cell #(
      .ENTRIES        (ENTRIES),
      .LINK_ADDR_BITS (LINK_ADDR_BITS),
      .IDX            (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .query_high     (query_high),
      .query_low      (query_low),
      .probe_in       (probe[i]),
      .probe_idx_in   (probe_idx[i]),
      .probe_link_in  (probe_link[i]),
      .probe_out      (probe[i+1]),
      .probe_idx_out  (probe_idx[i+1]),
      .probe_link_out (probe_link[i+1]),
      .wr             (wr),
      .wr_idx         (wr_idx),
      .wr_link        (wr_link)
    );
  end

endmodule
